/* src/pidffg_pkg.sv */
package pidffg_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int IDX_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FFEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR  = 3'd6;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_ERR  = 4'd2;
  localparam logic [3:0] OP_INT  = 4'd3;
  localparam logic [3:0] OP_KI   = 4'd4;
  localparam logic [3:0] OP_KD   = 4'd5;
  localparam logic [3:0] OP_KDA  = 4'd6;
  localparam logic [3:0] OP_MOD  = 4'd7;
  localparam logic [3:0] OP_FOLD = 4'd8;
  localparam logic [3:0] OP_CORD = 4'd9;
  localparam logic [3:0] OP_FIN  = 4'd10;

  localparam int MOD_TOP = 15;

  localparam logic [32:0] Q30_TWO_PI  = 33'd6746518852;
  localparam logic [31:0] Q30_PI      = 32'd3373259426;
  localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;
  localparam logic [29:0] Q30_GAIN    = 30'd652032874;

  typedef struct packed {
    logic [3:0]       op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/pidffg_ctrl.sv */
module pidffg_ctrl #(
  parameter int CORDIC_STEPS = pidffg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  input  pidffg_pkg::stat_t   stat,
  output pidffg_pkg::cmd_t    cmd
);
  import pidffg_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ERR  = 4'd1;
  localparam logic [3:0] ST_INT  = 4'd2;
  localparam logic [3:0] ST_KI   = 4'd3;
  localparam logic [3:0] ST_KD   = 4'd4;
  localparam logic [3:0] ST_KDA  = 4'd5;
  localparam logic [3:0] ST_MOD  = 4'd6;
  localparam logic [3:0] ST_FOLD = 4'd7;
  localparam logic [3:0] ST_CORD = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CORDIC_STEPS - 1);

  logic [3:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.op    = OP_NONE;
    cmd.idx   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = ST_INT;
      end
      ST_INT: begin
        cmd.op    = OP_INT;
        state_nxt = ST_KI;
      end
      ST_KI: begin
        cmd.op    = OP_KI;
        state_nxt = ST_KD;
      end
      ST_KD: begin
        cmd.op    = OP_KD;
        state_nxt = ST_KDA;
      end
      ST_KDA: begin
        cmd.op    = OP_KDA;
        idx_nxt   = IDX_W'(MOD_TOP);
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        cmd.op = OP_MOD;
        if (idx_r == '0) begin
          state_nxt = ST_FOLD;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      ST_FOLD: begin
        cmd.op    = OP_FOLD;
        idx_nxt   = '0;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        cmd.op = OP_CORD;
        if (idx_r == LAST_STEP) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (!stat.out_busy || out_ready) begin
          cmd.op    = OP_FIN;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

`ifndef SYNTHESIS
  a_mod_to_fold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD && idx_r == '0) |=> (state_r == ST_FOLD))
    else $error("reduction did not hand over to the fold step");
  a_cord_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORD) |-> (idx_r <= LAST_STEP))
    else $error("rotation counter ran past the step count");
  a_fin_next: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FIN) |=> (state_r == ST_IDLE))
    else $error("controller did not return to idle after a result");
`endif

endmodule

/* src/pidffg_dp.sv */
module pidffg_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pidffg_pkg::cmd_t                      cmd,
  output pidffg_pkg::stat_t                     stat,
  input  logic                                  cfg_we,
  input  logic [pidffg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidffg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [31:0]                    in_target_pos,
  input  logic signed [31:0]                    in_measured_pos,
  input  logic signed [31:0]                    in_next_command,
  input  logic signed [31:0]                    in_shaft_speed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [31:0]                    out_drive
);
  import pidffg_pkg::*;

  logic signed [31:0] kp_r, ki_r, kd_r;
  logic [30:0]        clamp_r;
  logic               ffen_r, gren_r;
  logic [31:0]        gear_r;

  logic signed [31:0] tgt_r, meas_r, cmdv_r, vel_r;
  logic signed [31:0] err_r, integ_r, grav_r, ffwd_r;
  logic signed [65:0] prod_r;
  logic signed [51:0] acc_r;
  logic [48:0]        z_r;
  logic signed [33:0] cx_r, cy_r, cz_r;
  logic               out_valid_r;
  logic signed [31:0] drive_r;

  logic signed [32:0] diff, isum, clamp_pos, clamp_neg, ma, mb;
  logic signed [31:0] err_sat, integ_nxt;
  logic signed [49:0] rnd;
  logic signed [47:0] ang;
  logic [48:0]        z_ld, mod_cmp;
  logic signed [33:0] zs, zf, dx, dy;
  logic [4:0]         ci;
  logic signed [33:0] at;
  logic signed [33:0] yr;
  logic signed [31:0] grav_new, grav_use, ffwd_use;
  logic signed [53:0] tot;
  logic signed [31:0] tot_sat;

  assign diff = 33'(tgt_r) - 33'(meas_r);
  assign err_sat = (diff > 33'sd2147483647) ? 32'sh7fffffff :
                   (diff < -33'sd2147483648) ? 32'sh80000000 : diff[31:0];

  assign isum      = 33'(integ_r) + 33'(err_r);
  assign clamp_pos = $signed({2'b00, clamp_r});
  assign clamp_neg = -clamp_pos;
  assign integ_nxt = (isum > clamp_pos) ? clamp_pos[31:0] :
                     (isum < clamp_neg) ? clamp_neg[31:0] : isum[31:0];

  always_comb begin
    case (cmd.op)
      OP_ERR: begin
        ma = 33'(meas_r);
        mb = $signed({1'b0, gear_r});
      end
      OP_INT: begin
        ma = 33'(kp_r);
        mb = 33'(err_r);
      end
      OP_KI: begin
        ma = 33'(ki_r);
        mb = 33'(integ_r);
      end
      default: begin
        ma = 33'(kd_r);
        mb = -33'(vel_r);
      end
    endcase
  end

  assign rnd = 50'((prod_r + 66'sd32768) >>> 16);

  assign ang  = prod_r[64:17];
  assign z_ld = ang[47] ? (49'($signed(ang)) + (49'(Q30_TWO_PI) << MOD_TOP))
                        : 49'($signed(ang));
  assign mod_cmp = 49'(Q30_TWO_PI) << cmd.idx;

  assign zs = (z_r[32:0] >= 33'(Q30_PI)) ? (34'(z_r[32:0]) - 34'(Q30_TWO_PI))
                                         : 34'(z_r[32:0]);
  assign zf = (zs > $signed(34'(Q30_HALF_PI)))  ? (34'(Q30_PI) - zs) :
              (zs < -$signed(34'(Q30_HALF_PI))) ? (-34'(Q30_PI) - zs) : zs;

  assign ci = cmd.idx;
  assign at = 34'(atan_q30(ci));
  assign dx = cy_r >>> ci;
  assign dy = cx_r >>> ci;

  assign yr       = (cy_r + 34'sd8192) >>> 14;
  assign grav_new = 32'(yr);
  assign grav_use = gren_r ? grav_new : grav_r;
  assign ffwd_use = ffen_r ? cmdv_r : ffwd_r;
  assign tot      = 54'(acc_r) + 54'(grav_use) + 54'(ffwd_use);
  assign tot_sat  = (tot > 54'sd2147483647) ? 32'sh7fffffff :
                    (tot < -54'sd2147483648) ? 32'sh80000000 : tot[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      clamp_r     <= 31'd327680;
      ffen_r      <= 1'b1;
      gren_r      <= 1'b1;
      gear_r      <= 32'h8000_0000;
      integ_r     <= '0;
      grav_r      <= '0;
      ffwd_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KP:    kp_r    <= cfg_data;
          REG_KI:    ki_r    <= cfg_data;
          REG_KD:    kd_r    <= cfg_data;
          REG_CLAMP: clamp_r <= cfg_data[30:0];
          REG_FFEN:  ffen_r  <= cfg_data[0];
          REG_GREN:  gren_r  <= cfg_data[0];
          REG_GEAR:  gear_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_INT) begin
        integ_r <= integ_nxt;
      end
      if (cmd.op == OP_FIN) begin
        grav_r      <= grav_use;
        ffwd_r      <= ffwd_use;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        tgt_r  <= in_target_pos;
        meas_r <= in_measured_pos;
        cmdv_r <= in_next_command;
        vel_r  <= in_shaft_speed;
      end
      OP_ERR: begin
        err_r  <= err_sat;
        prod_r <= ma * mb;
      end
      OP_INT: begin
        z_r    <= z_ld;
        prod_r <= ma * mb;
      end
      OP_KI: begin
        acc_r  <= 52'(rnd);
        prod_r <= ma * mb;
      end
      OP_KD: begin
        acc_r  <= acc_r + 52'(rnd);
        prod_r <= ma * mb;
      end
      OP_KDA: begin
        acc_r <= acc_r + 52'(rnd);
      end
      OP_MOD: begin
        if (z_r >= mod_cmp) begin
          z_r <= z_r - mod_cmp;
        end
      end
      OP_FOLD: begin
        cz_r <= zf;
        cx_r <= 34'(Q30_GAIN);
        cy_r <= '0;
      end
      OP_CORD: begin
        if (!cz_r[33]) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + at;
        end
      end
      OP_FIN: begin
        drive_r <= tot_sat;
      end
      default: ;
    endcase
  end

  assign stat.out_busy = out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_drive     = drive_r;

`ifndef SYNTHESIS
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FOLD) |=> (cz_r <= $signed(34'(Q30_HALF_PI)) &&
                             cz_r >= -$signed(34'(Q30_HALF_PI))))
    else $error("folded angle outside a quarter turn");
  a_mod_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_MOD && cmd.idx == '0) |=> (z_r < 49'(Q30_TWO_PI)))
    else $error("angle reduction left a full turn");
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(cmd.op) == OP_FIN))
    else $error("result raised without a finishing step");
`endif

endmodule

/* src/pid_position_controller_ffwd_gravity.sv */
// From input transfer to result: the error, integrator and shared-multiplier product steps,
// then angle reduction and one CORDIC iteration per cycle.
// One item is worked at a time, and a finished result waits in the output register while
// the next is taken.
// Reset is synchronous, active low; it restores register defaults and clears the held terms.
module pid_position_controller_ffwd_gravity #(
  parameter int CORDIC_STEPS = pidffg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pidffg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidffg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [31:0]                    in_target_pos,
  input  logic signed [31:0]                    in_measured_pos,
  input  logic signed [31:0]                    in_next_command,
  input  logic signed [31:0]                    in_shaft_speed,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [31:0]                    out_drive
);
  import pidffg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pidffg_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pidffg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_target_pos  (in_target_pos),
    .in_measured_pos(in_measured_pos),
    .in_next_command(in_next_command),
    .in_shaft_speed (in_shaft_speed),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_drive      (out_drive)
  );

endmodule

/* sim/pid_position_controller_ffwd_gravity_tb.sv */
`timescale 1ns / 100ps

module pid_position_controller_ffwd_gravity_tb;
  import pidffg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 60;
  localparam int LONG_HOLD = 500;

  typedef enum logic {ACT_ITEM, ACT_CFG} act_kind_t;

  typedef struct {
    act_kind_t            kind;
    logic [31:0]          tgt;
    logic [31:0]          meas;
    logic [31:0]          cmd;
    logic [31:0]          spd;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } act_t;

  localparam longint ATAN_Q30 [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2, 1, 0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_target_pos, in_measured_pos, in_next_command, in_shaft_speed;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_drive;

  pid_position_controller_ffwd_gravity dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_target_pos(in_target_pos), .in_measured_pos(in_measured_pos),
    .in_next_command(in_next_command), .in_shaft_speed(in_shaft_speed),
    .out_valid(out_valid), .out_ready(out_ready), .out_drive(out_drive)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Controller state mirrored by the testbench.
  longint kp, ki, kd, clamp, gear;
  logic ff_en, grav_en;
  longint integ, grav_hold, ff_hold;

  act_t pending[$];
  logic [31:0] drive_exp[$];
  int failures = 0;
  int results_seen = 0;

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    case (idx)
      REG_KP:    kp = sx32(d);
      REG_KI:    ki = sx32(d);
      REG_KD:    kd = sx32(d);
      REG_CLAMP: clamp = longint'(d[30:0]);
      REG_FFEN:  ff_en = d[0];
      REG_GREN:  grav_en = d[0];
      REG_GEAR:  gear = longint'(d);
      default: ;
    endcase
  endfunction

  function automatic longint joint_sine(longint pos);
    longint ang, x, y, z, dx, dy;
    int n;
    ang = (pos * gear) >>> 17;
    x = 652032874;
    y = 0;
    n = (CORDIC_STEPS_DEF > 32) ? 32 : CORDIC_STEPS_DEF;
    z = ang % 64'sd6746518852;
    if (z < 0) z += 64'sd6746518852;
    if (z >= 64'sd3373259426) z -= 64'sd6746518852;
    if (z > 64'sd1686629713) z = 64'sd3373259426 - z;
    else if (z < -64'sd1686629713) z = -64'sd3373259426 - z;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end
    end
    return sat32((y + 8192) >>> 14);
  endfunction

  function automatic logic [31:0] predict_drive(act_t a);
    longint err, acc;
    err = sat32(sx32(a.tgt) - sx32(a.meas));
    if (grav_en) grav_hold = joint_sine(sx32(a.meas));
    if (ff_en) ff_hold = sx32(a.cmd);
    acc = integ + err;
    if (acc > clamp) acc = clamp;
    else if (acc < -clamp) acc = -clamp;
    integ = acc;
    acc = grav_hold + ff_hold + mul_q16(kp, err) + mul_q16(ki, integ)
        + mul_q16(kd, -sx32(a.spd));
    return 32'(sat32(acc));
  endfunction

  function automatic void add_item(logic [31:0] t, logic [31:0] m, logic [31:0] c,
                                   logic [31:0] v);
    act_t a;
    a.kind = ACT_ITEM; a.tgt = t; a.meas = m; a.cmd = c; a.spd = v;
    a.idx = REG_KP; a.data = '0;
    pending.push_back(a);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    act_t a;
    a.kind = ACT_CFG; a.idx = idx; a.data = d;
    a.tgt = '0; a.meas = '0; a.cmd = '0; a.spd = '0;
    pending.push_back(a);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return $urandom;
      4: return $urandom;
      default: return 32'($signed($urandom_range(0, 2 * 600000)) - 600000);
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return rand_word();
      1: return 32'h0;
      default: return 32'($signed($urandom_range(0, 2 * 262144)) - 262144);
    endcase
  endfunction

  function automatic logic [31:0] rand_gear();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h0;
      2: return 32'hffff_ffff;
      3: return $urandom;
      default: return $urandom & 32'h7fff_ffff;
    endcase
  endfunction

  // Driver: items and register writes in queue order; writes only once the block is idle.
  act_t cur;
  int gap, settle;
  logic burst = 1'b0;
  logic nv, ncfg;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
      cfg_index <= REG_KP;
      cfg_data <= '0;
      in_target_pos <= '0;
      in_measured_pos <= '0;
      in_next_command <= '0;
      in_shaft_speed <= '0;
      gap = 0;
      settle = 0;
    end else begin
      nv = in_valid;
      ncfg = 1'b0;
      if (in_valid && in_ready) begin
        drive_exp.push_back(predict_drive(cur));
        nv = 1'b0;
        if ($urandom_range(0, 99) < 2) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 13);
      end
      if (drive_exp.size() != 0 || in_valid) settle = 0;
      else if (settle < 1000) settle++;
      if (!nv && pending.size() != 0 && pending[0].kind == ACT_CFG) begin
        if (settle >= SETTLE_CYCLES) begin
          ncfg = 1'b1;
          cfg_index <= pending[0].idx;
          cfg_data <= pending[0].data;
          write_reg(pending[0].idx, pending[0].data);
          void'(pending.pop_front());
        end
      end else if (!nv && gap > 0) begin
        gap--;
      end else if (!nv && pending.size() != 0) begin
        cur = pending.pop_front();
        nv = 1'b1;
        in_target_pos <= cur.tgt;
        in_measured_pos <= cur.meas;
        in_next_command <= cur.cmd;
        in_shaft_speed <= cur.spd;
      end
      in_valid <= nv;
      cfg_we <= ncfg;
    end
  end

  // Monitor: random stalls per transfer, and one long hold-off to back the block up.
  int stall = 0;
  int hold = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (drive_exp.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected result: drive %h", out_drive);
        end else if (out_drive !== drive_exp[0]) begin
          failures++;
          if (failures <= 10)
            $display("drive mismatch: expected %h, actual %h", drive_exp[0], out_drive);
          void'(drive_exp.pop_front());
        end else begin
          void'(drive_exp.pop_front());
        end
        if (results_seen == 150) hold = LONG_HOLD;
        stall = burst ? 0 : $urandom_range(0, 13);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    kp = 0; ki = 0; kd = 0; clamp = 327680; ff_en = 1'b1; grav_en = 1'b1;
    gear = 64'sd2147483648; integ = 0; grav_hold = 0; ff_hold = 0;

    // Reset settings: gravity and feed-forward only, with angles around the fold points.
    add_item(32'h0, 32'h0, 32'h0, 32'h0);
    add_item(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_item(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    add_item(32'h0, 32'd205887, 32'h0001_0000, 32'h0);
    add_item(32'h0, -32'sd205887, 32'hffff_0000, 32'h0);
    add_item(32'h0, 32'd102944, 32'h0, 32'h0);
    add_item(32'h0, -32'sd102944, 32'h0, 32'h0);
    add_item(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    // Unit proportional gain, full-scale integral and derivative gains and the widest integrator.
    add_cfg(REG_KP, 32'h0001_0000);
    add_cfg(REG_KI, 32'h8000_0000);
    add_cfg(REG_KD, 32'h7fff_ffff);
    add_cfg(REG_CLAMP, 32'hffff_ffff);
    add_cfg(REG_UNUSED, 32'h1234_5678);
    add_item(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h8000_0000);
    add_item(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
    add_item(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000);
    add_item(32'h0001_0000, 32'h0, 32'h0, 32'h0);
    // Held terms, a zero clamp and gear scales above and below one.
    add_cfg(REG_FFEN, 32'h0);
    add_cfg(REG_GREN, 32'hffff_fffe);
    add_cfg(REG_CLAMP, 32'h0);
    add_cfg(REG_GEAR, 32'hffff_ffff);
    add_cfg(REG_KD, 32'h0);
    add_item(32'h0003_0000, 32'h0, 32'h5555_5555, 32'h0);
    add_item(32'h0, 32'h7fff_ffff, 32'haaaa_aaaa, 32'h0);
    add_item(32'h0, 32'h8000_0000, 32'h0, 32'h0);
    add_cfg(REG_GEAR, 32'h0);
    add_cfg(REG_FFEN, 32'h1);
    add_item(32'h0, 32'h1234_5678, 32'h0002_0000, 32'h0);
    add_item(32'h0, 32'h8765_4321, 32'h0003_0000, 32'h0);

    for (int ph = 0; ph < 8; ph++) begin
      add_cfg(REG_KP, rand_gain());
      add_cfg(REG_KI, rand_gain());
      add_cfg(REG_KD, rand_gain());
      add_cfg(REG_CLAMP, ($urandom_range(0, 3) == 0) ? rand_word() : $urandom_range(0, 2000000));
      add_cfg(REG_FFEN, ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
      add_cfg(REG_GREN, ($urandom_range(0, 3) == 0) ? 32'h0 : 32'h1);
      add_cfg(REG_GEAR, rand_gear());
      for (int k = 0; k < 250; k++)
        add_item(rand_word(), rand_word(), rand_word(), rand_word());
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending.size() != 0 || in_valid || drive_exp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && drive_exp.size() == 0) begin
      $display("** pid_position_controller_ffwd_gravity: PASSED **");
    end else begin
      $display("** pid_position_controller_ffwd_gravity: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** pid_position_controller_ffwd_gravity: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
src/pidffg_pkg.sv
src/pidffg_ctrl.sv
src/pidffg_dp.sv
src/pid_position_controller_ffwd_gravity.sv
sim/pid_position_controller_ffwd_gravity_tb.sv
